// File: hw/rtl/utf8v_pkg.sv
// Shared types and constants for the UTF-8 string character validator.
// No dependencies; imported by utf8v_decode, the top level and the checker.

package utf8v_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX        = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_LOW_END  = 21'h00d7ff;
    localparam logic [CP_W-1:0] SURR_HIGH_END = 21'h00e000;
    localparam logic [CP_W-1:0] ASCII_TOP     = 21'h00007e;
    localparam logic [CP_W-1:0] ASCII_SPACE   = 21'h000020;
    localparam logic [CP_W-1:0] MIN_TWO       = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE     = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR      = 21'h010000;
    localparam logic [CP_W-1:0] TAB_CHAR      = 21'h000009;

    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_LEAD       = 3'd1,
        ERR_CONT       = 3'd2,
        ERR_OVERLONG   = 3'd3,
        ERR_RANGE      = 3'd4,
        ERR_DISALLOWED = 3'd5
    } utf8v_err_t;

    typedef struct packed {
        logic [1:0]      bytes_left;
        logic [2:0]      seq_len;
        logic [CP_W-1:0] partial_value;
        logic            seq_ok;
    } utf8v_state_t;

    typedef struct packed {
        logic            char_done;
        logic [CP_W-1:0] code_point;
        logic [2:0]      char_length;
        utf8v_err_t      error_code;
    } utf8v_result_t;

endpackage

// File: hw/rtl/utf8v_decode.sv
// Per-byte UTF-8 decode step: next sequence state and the result for one byte.
// Pure combinational logic; depends on utf8v_pkg.

module utf8v_decode (
    input  utf8v_pkg::utf8v_state_t  state,
    input  logic [7:0]               data_byte,
    input  logic                     restart,
    output utf8v_pkg::utf8v_state_t  state_next,
    output utf8v_pkg::utf8v_result_t result
);
    import utf8v_pkg::*;

    logic [1:0]      bl;
    logic [CP_W-1:0] pv;
    logic            ok;
    logic [CP_W-1:0] cp;
    logic [2:0]      len;
    logic [1:0]      bl_next;
    logic            ok_next;
    utf8v_err_t      err_byte;
    utf8v_err_t      err_char;
    logic            allowed;

    // restart drops the open sequence before the byte is looked at
    always_comb
    begin
        bl = restart ? 2'd0 : state.bytes_left;
        pv = restart ? '0 : state.partial_value;
        ok = restart ? 1'b1 : state.seq_ok;
    end

    always_comb
    begin
        cp       = pv;
        len      = state.seq_len;
        bl_next  = bl;
        ok_next  = ok;
        err_byte = ERR_NONE;
        if (bl == 2'd0)
        begin
            ok_next = 1'b1;
            if (data_byte[7] == 1'b0)
            begin
                cp  = {13'd0, data_byte};
                len = LEN_ONE;
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                cp  = {10'd0, data_byte[4:0], 6'd0};
                len = LEN_TWO;
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                cp  = {5'd0, data_byte[3:0], 12'd0};
                len = LEN_THREE;
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                cp  = {data_byte[2:0], 18'd0};
                len = LEN_FOUR;
            end
            else
            begin
                cp       = '0;
                len      = LEN_ONE;
                ok_next  = 1'b0;
                err_byte = ERR_LEAD;
            end
            bl_next = 2'(len - 3'd1);
        end
        else
        begin
            if (data_byte[7:6] == 2'b10)
            begin
                case (bl)
                    2'd1:    cp = pv | {15'd0, data_byte[5:0]};
                    2'd2:    cp = pv | {9'd0, data_byte[5:0], 6'd0};
                    default: cp = pv | {3'd0, data_byte[5:0], 12'd0};
                endcase
            end
            else
            begin
                ok_next  = 1'b0;
                err_byte = ERR_CONT;
            end
            bl_next = bl - 2'd1;
        end
    end

    // character checks on the finished code point, in priority order
    always_comb
    begin
        allowed = (cp == TAB_CHAR)
                || (cp >= ASCII_SPACE && cp <= ASCII_TOP)
                || (cp >= MIN_TWO && cp <= SURR_LOW_END)
                || (cp >= SURR_HIGH_END);
        if ((len == LEN_TWO && cp < MIN_TWO) || (len == LEN_THREE && cp < MIN_THREE)
            || (len == LEN_FOUR && cp < MIN_FOUR))
            err_char = ERR_OVERLONG;
        else if (cp > CP_MAX)
            err_char = ERR_RANGE;
        else if (!allowed)
            err_char = ERR_DISALLOWED;
        else
            err_char = ERR_NONE;
    end

    always_comb
    begin
        state_next.bytes_left    = bl_next;
        state_next.seq_len       = len;
        state_next.partial_value = cp;
        state_next.seq_ok        = ok_next;

        result.char_done   = (bl_next == 2'd0);
        result.code_point  = cp;
        result.char_length = len;
        if (err_byte != ERR_NONE)
            result.error_code = err_byte;
        else if (bl_next != 2'd0)
            result.error_code = ERR_NONE;
        else if (!ok_next)
            result.error_code = ERR_CONT;
        else
            result.error_code = err_char;
    end

endmodule

// File: hw/rtl/utf8_string_char_validator.sv
// Top level of the UTF-8 string character validator: input register,
// decode step, sequence state and result register. Uses utf8v_pkg, utf8v_decode.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat carries one byte of the
//   string body in data_byte; restart=1 drops any unfinished sequence
//   before that byte is decoded (use it at the start of each new string).
//   Output channel (out_valid / out_stall): exactly one beat per input
//   beat, in order: char_done, code_point, char_length, error_code.
//   Path: an accepted byte waits in the input register, then is decoded
//   into the result register and shows on the output from then on.
//   Throughput: one byte per cycle while the receiver does not stall. The
//   decode is one shallow compare and shift step, and the sequence state
//   updates in the same cycle, so a byte can follow its predecessor directly.
//   Stall: the input register and the result register together hold two
//   beats. While the receiver stalls, a waiting result holds still and one
//   more byte is taken into the input register; in_stall rises only when
//   both are full. in_stall does not look at in_valid.
//   Reset (rst_n low, asynchronous): both registers empty, no sequence
//   open (bytes_left 0, seq_len 1, partial value 0, sequence ok).

module utf8_string_char_validator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        char_done,
    output logic [20:0] code_point,
    output logic [2:0]  char_length,
    output logic [2:0]  error_code
);
    import utf8v_pkg::*;

    logic          in_full_reg;
    logic          in_full_next;
    logic [7:0]    byte_reg;
    logic          restart_reg;
    utf8v_state_t  state_reg;
    utf8v_state_t  state_next;
    utf8v_result_t dec_result;
    utf8v_result_t result_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          advance;

    // held byte moves on when the result register is free or being drained
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !(!out_valid_reg || !out_stall);

    always_comb
    begin
        in_full_next = in_full_reg;
        if (!in_stall)
            in_full_next = in_valid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    utf8v_decode u_decode (
        .state      (state_reg),
        .data_byte  (byte_reg),
        .restart    (restart_reg),
        .state_next (state_next),
        .result     (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg             <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.bytes_left    <= 2'd0;
            state_reg.seq_len       <= LEN_ONE;
            state_reg.partial_value <= '0;
            state_reg.seq_ok        <= 1'b1;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg    <= data_byte;
            restart_reg <= restart;
        end
        if (advance)
            result_reg <= dec_result;
    end

    assign out_valid   = out_valid_reg;
    assign char_done   = result_reg.char_done;
    assign code_point  = result_reg.code_point;
    assign char_length = result_reg.char_length;
    assign error_code  = result_reg.error_code;

endmodule

// File: hw/rtl/utf8v_checker.sv
// Port-level checks for utf8_string_char_validator, bound to the top level.
// Uses utf8v_pkg.

module utf8v_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        char_done,
    input logic [20:0] code_point,
    input logic [2:0]  char_length,
    input logic [2:0]  error_code
);
    import utf8v_pkg::*;

    // a byte that leaves its sequence open is either clean or a bad continuation
    a_mid_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_done |-> error_code == ERR_NONE || error_code == ERR_CONT)
        else $error("mid-sequence beat with a character-level error");

    // only multi-byte sequences can leave a byte unfinished
    a_mid_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_done |-> char_length == LEN_TWO || char_length == LEN_THREE
                                 || char_length == LEN_FOUR)
        else $error("unfinished beat with a one-byte length");

    // a bad lead byte is consumed alone with an empty code point
    a_bad_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_LEAD |->
            char_done && char_length == LEN_ONE && code_point == '0)
        else $error("bad lead beat malformed");

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_point)
                                 && $stable(error_code) && $stable(char_done))
        else $error("stalled output beat changed");

endmodule

bind utf8_string_char_validator utf8v_checker u_utf8v_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_done   (char_done),
    .code_point  (code_point),
    .char_length (char_length),
    .error_code  (error_code)
);

// File: verif/tb_utf8_string_char_validator.sv
// Self-checking testbench for utf8_string_char_validator: directed and random byte streams,
// per-byte decode prediction, field-by-field result checks.
// Depends on utf8v_pkg and the utf8_string_char_validator RTL.

module tb_utf8_string_char_validator;

    import utf8v_pkg::*;

    // Quiet cycles (no beat on either channel) before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;
    // Bytes per random phase; six phases give the random part.
    localparam int PHASE_BYTES = 300;
    localparam int NUM_PHASES  = 6;

    // One queued input beat.
    typedef struct {
        logic [7:0] value;
        logic       restart_flag;
        int         gap_after;
    } body_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        char_done;
    logic [20:0] code_point;
    logic [2:0]  char_length;
    logic [2:0]  error_code;

    // Beats still to drive, and decode results still owed by the block.
    body_byte_t    byte_backlog[$];
    utf8v_result_t char_reports_due[$];

    // Handshake seen at the last rising edge, used by the falling-edge drivers.
    logic in_fired = 1'b0;
    logic out_fired = 1'b0;

    // Idle shaping: current upper bounds for sender gaps and receiver stalls.
    int tx_max_gap = 0;
    int rx_max_wait = 0;
    int gap_left = 0;
    int stall_left = 0;

    int queued_bytes = 0;
    int mismatch_cnt = 0;

    // Decoder state mirrored by the predictor.
    logic [1:0]      dec_left = 2'd0;
    logic [2:0]      dec_len = LEN_ONE;
    logic [CP_W-1:0] dec_cp = '0;
    logic            dec_ok = 1'b1;

    // Code points around the class boundaries, all but the four-byte minimum (10000).
    logic [CP_W-1:0] corner_cp[16] = '{
        21'h000000, 21'h000009, 21'h00000a, 21'h00001f,
        21'h000020, 21'h00007e, 21'h00007f, 21'h000080,
        21'h0007ff, 21'h000800, 21'h00d7ff, 21'h00d800,
        21'h00dfff, 21'h00e000, 21'h10ffff, 21'h110000
    };

    utf8_string_char_validator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_done   (char_done),
        .code_point  (code_point),
        .char_length (char_length),
        .error_code  (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Classify a finished, well-formed sequence: overlong first, then range,
    // then whether the character may appear in a string body.
    function automatic utf8v_err_t classify_char(input logic [CP_W-1:0] cp,
                                                 input logic [2:0] len);
        if ((len == LEN_TWO && cp < MIN_TWO) || (len == LEN_THREE && cp < MIN_THREE) ||
            (len == LEN_FOUR && cp < MIN_FOUR))
            return ERR_OVERLONG;
        if (cp > CP_MAX)
            return ERR_RANGE;
        if (!(cp == TAB_CHAR || (cp >= ASCII_SPACE && cp <= ASCII_TOP) ||
              (cp >= MIN_TWO && cp <= SURR_LOW_END) || cp >= SURR_HIGH_END))
            return ERR_DISALLOWED;
        return ERR_NONE;
    endfunction

    // Advance the mirrored decoder by one byte and return the report it owes.
    function automatic utf8v_result_t decode_byte(input logic [7:0] b, input logic rs);
        utf8v_result_t rep;
        utf8v_err_t    err;
        err = ERR_NONE;
        rep.char_done = 1'b0;
        if (rs)
        begin
            dec_left = 2'd0;
            dec_cp   = '0;
            dec_ok   = 1'b1;
        end
        if (dec_left == 2'd0)
        begin
            // Lead byte: opens a sequence, or is a one-byte bad lead.
            dec_ok = 1'b1;
            if (b[7] == 1'b0)
            begin
                dec_cp  = CP_W'(b);
                dec_len = LEN_ONE;
            end
            else if (b[7:5] == 3'b110)
            begin
                dec_cp  = CP_W'({b[4:0], 6'd0});
                dec_len = LEN_TWO;
            end
            else if (b[7:4] == 4'b1110)
            begin
                dec_cp  = CP_W'({b[3:0], 12'd0});
                dec_len = LEN_THREE;
            end
            else if (b[7:3] == 5'b11110)
            begin
                dec_cp  = {b[2:0], 18'd0};
                dec_len = LEN_FOUR;
            end
            else
            begin
                dec_cp  = '0;
                dec_len = LEN_ONE;
                dec_ok  = 1'b0;
                err     = ERR_LEAD;
            end
            dec_left = 2'(dec_len - 3'd1);
        end
        else
        begin
            // Any byte inside a sequence is consumed; only 10xxxxxx adds bits.
            if (b[7:6] == 2'b10)
                dec_cp = dec_cp | (CP_W'(b[5:0]) << (6 * (dec_left - 2'd1)));
            else
            begin
                dec_ok = 1'b0;
                err    = ERR_CONT;
            end
            dec_left = dec_left - 2'd1;
        end
        if (dec_left == 2'd0)
        begin
            rep.char_done = 1'b1;
            if (err == ERR_NONE)
                err = dec_ok ? classify_char(dec_cp, dec_len) : ERR_CONT;
        end
        rep.code_point  = dec_cp;
        rep.char_length = dec_len;
        rep.error_code  = err;
        return rep;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic rs);
        body_byte_t item;
        item.value        = b;
        item.restart_flag = rs;
        item.gap_after    = $urandom_range(0, tx_max_gap);
        byte_backlog.insert(byte_backlog.size(), item);
        queued_bytes++;
    endtask

    // Encode cp as a len-byte sequence. bad_pos picks a continuation slot
    // (1..len-1) to replace with a non-continuation byte; keep truncates.
    task automatic push_char(input logic [CP_W-1:0] cp, input int len, input logic rs,
                             input int bad_pos, input int keep);
        logic [7:0] b;
        int         k;
        case (len)
            1:       b = {1'b0, cp[6:0]};
            2:       b = {3'b110, cp[10:6]};
            3:       b = {4'b1110, cp[15:12]};
            default: b = {5'b11110, cp[20:18]};
        endcase
        push_byte(b, rs);
        for (k = len - 2; k >= 0 && (len - 1 - k) < keep; k--)
        begin
            b = {2'b10, cp[6*k +: 6]};
            if ((len - 1 - k) == bad_pos)
            begin
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
            end
            push_byte(b, $urandom_range(0, 49) == 0);
        end
    endtask

    task automatic push_random_unit();
        logic [CP_W-1:0] cp;
        int              pick;
        int              len;
        logic            rs;
        pick = $urandom_range(0, 99);
        rs   = ($urandom_range(0, 19) == 0);
        if (pick < 45)
        begin
            // Well-formed shape, random payload bits.
            len = $urandom_range(1, 4);
            cp  = CP_W'($urandom);
            push_char(cp, len, rs, -1, len);
        end
        else if (pick < 70)
        begin
            // Boundary code point, shortest form or sometimes a longer one.
            cp  = corner_cp[4'($urandom_range(0, 15))] + CP_W'($urandom_range(0, 1));
            len = (cp < MIN_TWO) ? 1 : (cp < MIN_THREE) ? 2 : (cp < MIN_FOUR) ? 3 : 4;
            if (len < 4 && $urandom_range(0, 4) == 0)
                len = $urandom_range(len + 1, 4);
            push_char(cp, len, rs, -1, len);
        end
        else if (pick < 85)
        begin
            // Broken sequence: bad continuation, or cut short and followed by an ASCII byte that sometimes restarts.
            len = $urandom_range(2, 4);
            cp  = CP_W'($urandom);
            if ($urandom_range(0, 1) == 0)
                push_char(cp, len, rs, $urandom_range(1, len - 1), len);
            else
            begin
                push_char(cp, len, rs, -1, $urandom_range(0, len - 2));
                push_char(CP_W'($urandom_range(0, 127)), 1, 1'($urandom_range(0, 1)), -1, 1);
            end
        end
        else
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    endtask

    // Sender: a beat holds until taken; a new one goes out once the gap
    // drawn for the previous beat has run down.
    always @(negedge clk)
    begin : byte_driver
        body_byte_t nxt;
        if (rst_n && (!in_valid || in_fired))
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (byte_backlog.size() != 0)
            begin
                nxt = byte_backlog.pop_front();
                gap_left = nxt.gap_after;
                in_valid  <= 1'b1;
                data_byte <= nxt.value;
                restart   <= nxt.restart_flag;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: after each result beat, stall for a freshly drawn count.
    always @(negedge clk)
    begin : result_stall
        if (rst_n)
        begin
            if (out_fired)
                stall_left = $urandom_range(0, rx_max_wait);
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: results are checked before the new byte's report is queued,
    // since a result never belongs to a byte taken at the same edge.
    always @(posedge clk)
    begin : beat_monitor
        utf8v_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (char_reports_due.size() == 0)
                begin
                    $error("result beat with no byte outstanding");
                    mismatch_cnt++;
                end
                else
                begin
                    want = char_reports_due.pop_front();
                    if (char_done !== want.char_done)
                    begin
                        $error("char_done expected %0d actual %0d", want.char_done, char_done);
                        mismatch_cnt++;
                    end
                    if (code_point !== want.code_point)
                    begin
                        $error("code_point expected %0h actual %0h",
                               want.code_point, code_point);
                        mismatch_cnt++;
                    end
                    if (char_length !== want.char_length)
                    begin
                        $error("char_length expected %0d actual %0d",
                               want.char_length, char_length);
                        mismatch_cnt++;
                    end
                    if (error_code !== want.error_code)
                    begin
                        $error("error_code expected %0d actual %0d",
                               want.error_code, error_code);
                        mismatch_cnt++;
                    end
                end
            end
            if (in_valid && !in_stall)
                char_reports_due.insert(char_reports_due.size(),
                                        decode_byte(data_byte, restart));
        end
        in_fired  <= rst_n && in_valid && !in_stall;
        out_fired <= rst_n && out_valid && !out_stall;
    end

    // Hang guard: too long with no beat on either side ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
                quiet = 0;
            else
                quiet++;
        end
        $display("[utf8_string_char_validator] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int target;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: controls, tab, DEL, bad leads, a valid two-byte char,
        // overlong, bad continuation mid-sequence, surrogate, above max,
        // restart dropping an open sequence, largest 4-byte value.
        push_byte(8'h00, 1'b0);
        push_byte(8'h09, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hff, 1'b0);
        push_char(21'h0000a9, 2, 1'b0, -1, 2);
        push_char(21'h000000, 2, 1'b0, -1, 2);
        push_byte(8'he2, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hac, 1'b0);
        push_char(21'h00d800, 3, 1'b0, -1, 3);
        push_char(21'h110000, 4, 1'b0, -1, 4);
        push_byte(8'he2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h7e, 1'b1);
        push_char(21'h1fffff, 4, 1'b0, -1, 4);

        // Random phases: no idling, both sides idling, sender only, receiver only.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            while (byte_backlog.size() != 0)
                @(posedge clk);
            tx_max_gap  = (p % 4 == 1 || p % 4 == 2) ? 8 : 0;
            rx_max_wait = (p % 4 == 1 || p % 4 == 3) ? 8 : 0;
            target = queued_bytes + PHASE_BYTES;
            while (queued_bytes < target)
                push_random_unit();
        end

        while (byte_backlog.size() != 0 || in_valid || char_reports_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_cnt == 0 && char_reports_due.size() == 0)
            $display("[utf8_string_char_validator] OK");
        else
            $display("[utf8_string_char_validator] ERROR");
        $finish;
    end

endmodule

// File: utf8_string_char_validator.f
hw/rtl/utf8v_pkg.sv
hw/rtl/utf8v_decode.sv
hw/rtl/utf8_string_char_validator.sv
hw/rtl/utf8v_checker.sv
verif/tb_utf8_string_char_validator.sv
